FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: design/mbfe_pkg.sv
// ----------------------------------------------------------------------------
// mbfe_pkg
// Types and constants shared by the message bit-field extractor modules.
// ----------------------------------------------------------------------------
package mbfe_pkg;

	// Message buffer geometry.
	localparam int BUF_BYTES = 64;
	localparam int IDX_W     = $clog2(BUF_BYTES);
	localparam int CNT_W     = IDX_W + 1;

	// A field of up to 64 bits touches at most nine bytes.
	localparam int MAX_BYTES = 9;
	localparam int ACC_W     = 8 * MAX_BYTES;

	// Depth of the command queue between front and back.
	localparam int CMDQ_DEPTH = 2;

	// Item kinds on the input.
	localparam logic [1:0] KIND_LOAD     = 2'd0;
	localparam logic [1:0] KIND_UNSIGNED = 2'd1;
	localparam logic [1:0] KIND_SIGNED   = 2'd2;

	// Commands handed from front to back.
	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_EXTRACT = 2'd1;
	localparam logic [1:0] CMD_ERROR   = 2'd2;

	// Length limits per mode.
	localparam logic [6:0] MAX_UNSIGNED_LEN = 7'd64;
	localparam logic [6:0] MAX_SIGNED_LEN   = 7'd32;

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] byte_index;
		logic [7:0] byte_value;
		logic [8:0] bit_offset;
		logic [6:0] field_length;
	} in_item_t;

	typedef struct packed {
		logic [63:0] field_value;
		logic        length_error;
	} out_item_t;

	// Classified command: a load, an extract with its byte window, or an error.
	typedef struct packed {
		logic [1:0]       op;
		logic [IDX_W-1:0] idx;
		logic [7:0]       val;
		logic [IDX_W-1:0] start_byte;
		logic [3:0]       nbytes;
		logic [2:0]       trail;
		logic [6:0]       len;
		logic             sgn;
	} cmd_t;

endpackage

FILE: design/mbfe_cmd_queue.sv
// ----------------------------------------------------------------------------
// mbfe_cmd_queue
// Short command queue that decouples the classifying front from the back.
// ----------------------------------------------------------------------------
module mbfe_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mbfe_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output mbfe_pkg::cmd_t rdata
);
	import mbfe_pkg::*;

	localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CNT_QW = $clog2(CMDQ_DEPTH + 1);

	cmd_t              slot_q [CMDQ_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == CNT_QW'(CMDQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	// Pointer and occupancy bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

FILE: design/mbfe_front.sv
// ----------------------------------------------------------------------------
// mbfe_front
// Accepts input beats, checks lengths and works out the byte window of a field.
// ----------------------------------------------------------------------------
module mbfe_front (
	input  logic              push,
	input  mbfe_pkg::in_item_t item,
	input  logic              q_full,
	output logic              q_push,
	output mbfe_pkg::cmd_t    cmd
);
	import mbfe_pkg::*;

	logic [9:0] end_bit;
	logic [6:0] first_byte;
	logic [6:0] last_byte;
	logic [6:0] span;
	logic       len_bad;

	// Last bit of the field and the bytes it spans.
	assign end_bit    = {1'b0, item.bit_offset} + {3'b0, item.field_length} - 10'd1;
	assign first_byte = {1'b0, item.bit_offset[8:3]};
	assign last_byte  = end_bit[9:3];
	assign span       = last_byte - first_byte;

	// Length check per mode.
	always_comb begin
		case (item.kind)
			KIND_UNSIGNED: len_bad = (item.field_length == 7'd0) ||
				(item.field_length > MAX_UNSIGNED_LEN);
			KIND_SIGNED:   len_bad = (item.field_length == 7'd0) ||
				(item.field_length > MAX_SIGNED_LEN);
			default:       len_bad = 1'b0;
		endcase
	end

	// Classify the beat; kind three is dropped here.
	always_comb begin
		cmd.idx        = item.byte_index;
		cmd.val        = item.byte_value;
		cmd.start_byte = item.bit_offset[8:3];
		cmd.nbytes     = span[3:0] + 4'd1;
		cmd.trail      = 3'd7 - end_bit[2:0];
		cmd.len        = item.field_length;
		cmd.sgn        = (item.kind == KIND_SIGNED);
		case (item.kind)
			KIND_LOAD: begin
				cmd.op = CMD_LOAD;
				q_push = push && !q_full;
			end
			KIND_UNSIGNED, KIND_SIGNED: begin
				cmd.op = len_bad ? CMD_ERROR : CMD_EXTRACT;
				q_push = push && !q_full;
			end
			default: begin
				cmd.op = CMD_ERROR;
				q_push = 1'b0;
			end
		endcase
	end

endmodule

FILE: design/mbfe_back.sv
// ----------------------------------------------------------------------------
// mbfe_back
// Owns the byte memory: performs loads, gathers field bytes one per cycle,
// aligns and sign-converts the field, and queues the results.
// ----------------------------------------------------------------------------
module mbfe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_empty,
	input  mbfe_pkg::cmd_t     cmd,
	output logic               cmd_pop,
	output logic               empty,
	input  logic               pop,
	output mbfe_pkg::out_item_t result
);
	import mbfe_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_ALIGN = 3'd3;
	localparam logic [2:0] ST_SIGN  = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	localparam int RES_DEPTH = 2;

	// Mask of the low len bits; len of 64 gives all ones.
	function automatic logic [63:0] low_mask(input logic [6:0] len);
		low_mask = ~({64{1'b1}} << len);
	endfunction

	logic [7:0]       mem [BUF_BYTES];
	logic [2:0]       state_q;
	logic [CNT_W-1:0] loaded_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [3:0]       cnt_q;
	logic             dv_q;
	logic             rd_ok_q;
	logic [7:0]       rdata_q;
	logic [ACC_W-1:0] acc_q;
	logic [2:0]       trail_q;
	logic [6:0]       len_q;
	logic             sgn_q;
	logic [63:0]      raw_q;
	logic [63:0]      res_val_q;
	logic             res_err_q;
	logic             is_load;
	logic [CNT_W-1:0] idx_next;
	logic [ACC_W-1:0] shifted;
	logic [6:0]       len_m1;
	logic [63:0]      mag;
	logic [63:0]      final_val;
	out_item_t        res_slot_q [RES_DEPTH];
	logic             res_wr_q;
	logic             res_rd_q;
	logic [1:0]       res_cnt_q;
	logic             res_full;
	logic             res_push;
	logic             res_pop;

	assign cmd_pop  = (state_q == ST_IDLE) && !cmd_empty;
	assign is_load  = cmd_pop && (cmd.op == CMD_LOAD);
	assign idx_next = {1'b0, cmd.idx} + CNT_W'(1);

	// Field alignment and sign-magnitude conversion.
	assign shifted   = acc_q >> trail_q;
	assign len_m1    = len_q - 7'd1;
	assign mag       = raw_q & low_mask(len_m1);
	assign final_val = !sgn_q ? raw_q :
		(raw_q[len_m1[5:0]] ? (64'd0 - mag) : mag);

	// Result queue handshake.
	assign res_full = (res_cnt_q == 2'd2);
	assign empty    = (res_cnt_q == 2'd0);
	assign res_push = (state_q == ST_OUT) && !res_full;
	assign res_pop  = pop && !empty;
	assign result   = res_slot_q[res_rd_q];

	// Sequencer and loaded length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			loaded_q <= '0;
			rd_idx_q <= '0;
			cnt_q    <= '0;
			dv_q     <= 1'b0;
		end else begin
			dv_q <= (state_q == ST_READ);
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						case (cmd.op)
							CMD_LOAD: begin
								if (cmd.idx == '0) begin
									loaded_q <= CNT_W'(1);
								end else if (idx_next > loaded_q) begin
									loaded_q <= idx_next;
								end
							end
							CMD_EXTRACT: begin
								rd_idx_q <= {1'b0, cmd.start_byte};
								cnt_q    <= cmd.nbytes;
								state_q  <= ST_READ;
							end
							default: begin
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_READ: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					cnt_q    <= cnt_q - 4'd1;
					if (cnt_q == 4'd1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_ALIGN;
				ST_ALIGN: state_q <= ST_SIGN;
				ST_SIGN:  state_q <= ST_OUT;
				ST_OUT: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Byte memory: one write port for loads, one registered read port.
	always_ff @(posedge clk) begin
		if (is_load) begin
			mem[cmd.idx] <= cmd.val;
		end
		if (state_q == ST_READ) begin
			rdata_q <= mem[rd_idx_q[IDX_W-1:0]];
			rd_ok_q <= (rd_idx_q < loaded_q);
		end
	end

	// Datapath: gather bytes, align, convert.
	always_ff @(posedge clk) begin
		if (dv_q) begin
			acc_q <= {acc_q[ACC_W-9:0], (rd_ok_q ? rdata_q : 8'd0)};
		end
		if (cmd_pop) begin
			trail_q <= cmd.trail;
			len_q   <= cmd.len;
			sgn_q   <= cmd.sgn;
		end
		if (state_q == ST_ALIGN) begin
			raw_q <= shifted[63:0] & low_mask(len_q);
		end
		if (cmd_pop && (cmd.op == CMD_ERROR)) begin
			res_val_q <= '0;
			res_err_q <= 1'b1;
		end else if (state_q == ST_SIGN) begin
			res_val_q <= final_val;
			res_err_q <= 1'b0;
		end
	end

	// Result queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= 1'b0;
			res_rd_q  <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			if (res_push) begin
				res_wr_q <= ~res_wr_q;
			end
			if (res_pop) begin
				res_rd_q <= ~res_rd_q;
			end
			if (res_push && !res_pop) begin
				res_cnt_q <= res_cnt_q + 2'd1;
			end else if (res_pop && !res_push) begin
				res_cnt_q <= res_cnt_q - 2'd1;
			end
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (res_push) begin
			res_slot_q[res_wr_q] <= '{field_value: res_val_q, length_error: res_err_q};
		end
	end

endmodule

FILE: design/message_bit_field_extractor_top.sv
// ----------------------------------------------------------------------------
// message_bit_field_extractor_top
// Message buffer with MSB-first bit-field extraction, unsigned or
// sign-magnitude.
// ----------------------------------------------------------------------------
// A load beat is handled in the idle state of the back end. An extract beat
// passes the read, drain, align, sign and output states and reads its one to
// nine bytes one at a time through the single read port of the byte memory;
// a beat with a bad length goes straight to the output state. Beats are taken
// on push while full is low and results wait in a two-entry queue, so a
// stalled pop does not stop new beats until the command queue fills. Bits
// past the loaded length read as zero; a signed field returns sign-extended.
// ----------------------------------------------------------------------------
module message_bit_field_extractor_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  mbfe_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output mbfe_pkg::out_item_t result
);
	import mbfe_pkg::*;

	cmd_t front_cmd;
	cmd_t head_cmd;
	logic q_push;
	logic q_empty;
	logic q_pop;

	// Front: classify beats.
	mbfe_front u_front (
		.push   (push),
		.item   (item),
		.q_full (full),
		.q_push (q_push),
		.cmd    (front_cmd)
	);

	// Queue between front and back.
	mbfe_cmd_queue u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (front_cmd),
		.full   (full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (head_cmd)
	);

	// Back: memory, extraction and result queue.
	mbfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (q_empty),
		.cmd       (head_cmd),
		.cmd_pop   (q_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

FILE: design/mbfe_checker.sv
// ----------------------------------------------------------------------------
// mbfe_checker
// Port-level checks of the message bit-field extractor, bound to its top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbfe_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                full,
	input logic                empty,
	input logic                pop,
	input mbfe_pkg::out_item_t result
);
	import mbfe_pkg::*;

	// A length error always comes with a zero value.
	`ASSERT_IMP(a_err_zero, clk, arst_n, !empty && result.length_error, result.field_value == 64'd0)

	// Right after reset nothing is queued and beats are taken.
	`ASSERT_IMP(a_reset_clean, clk, arst_n, $rose(arst_n), empty && !full)

	// A waiting result holds until it is popped.
	`ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(result))

endmodule

bind message_bit_field_extractor_top mbfe_checker u_mbfe_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the message bit-field extractor. A short table of
// directed beats covers the length limits, the buffer ends and the signed
// corner cases. Random message loads and field reads follow, checked against
// a bit-level predictor, with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module testbench;

	import mbfe_pkg::*;

	// The fourth kind code has no meaning and must be dropped.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam int RANDOM_BEATS = 800;
	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE       = 30;

	typedef struct {
		in_item_t  beat;
		bit        typed;
		out_item_t res;
	} stim_row_t;

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      empty;
	logic      pop;
	out_item_t result;

	// Typed-in expectation that travels with the beat on the input.
	bit        drv_typed;
	out_item_t drv_res;

	// Shadow of the message buffer, as the block should hold it.
	logic [7:0] msg_bytes [BUF_BYTES];
	bit         msg_written [BUF_BYTES];
	logic [6:0] msg_len;

	out_item_t  pending_fields [$];
	stim_row_t  dir_rows [$];
	int         fail_count;
	int         beats_taken;
	int         idle_cycles;
	int         burst_left;
	bit         hold_req;

	message_bit_field_extractor_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// One message bit, MSB first; bits past the loaded length read as zero.
	function automatic logic msg_bit(int unsigned pos);
		int unsigned b;
		b = pos >> 3;
		if (b >= msg_len || b >= BUF_BYTES)
			return 1'b0;
		return msg_bytes[b][7 - (pos & 7)];
	endfunction

	function automatic logic [63:0] gather_field(int unsigned start, int unsigned len);
		logic [63:0] acc;
		acc = '0;
		for (int unsigned i = 0; i < len; i++)
			acc = {acc[62:0], msg_bit(start + i)};
		return acc;
	endfunction

	// Applies one accepted beat to the shadow buffer and works out its field.
	task automatic apply_beat(input in_item_t b, output bit has_res, output out_item_t res);
		logic [63:0] mag;
		has_res = 1'b0;
		res = '0;
		case (b.kind)
			KIND_LOAD: begin
				msg_bytes[b.byte_index] = b.byte_value;
				msg_written[b.byte_index] = 1'b1;
				if (b.byte_index == 0)
					msg_len = 7'd1;
				else if (b.byte_index + 7'd1 > msg_len)
					msg_len = b.byte_index + 7'd1;
			end
			KIND_UNSIGNED: begin
				has_res = 1'b1;
				if (b.field_length == 0 || b.field_length > MAX_UNSIGNED_LEN)
					res.length_error = 1'b1;
				else
					res.field_value = gather_field(b.bit_offset, b.field_length);
			end
			KIND_SIGNED: begin
				has_res = 1'b1;
				if (b.field_length == 0 || b.field_length > MAX_SIGNED_LEN) begin
					res.length_error = 1'b1;
				end else begin
					mag = gather_field(b.bit_offset + 1, b.field_length - 1);
					res.field_value = msg_bit(b.bit_offset) ? (64'd0 - mag) : mag;
				end
			end
			default: has_res = 1'b0;
		endcase
	endtask

	// A field read must not touch a byte inside the loaded length that was
	// never written.
	function automatic bit reads_ok(in_item_t b);
		int unsigned first;
		int unsigned last;
		if (b.kind == KIND_UNSIGNED &&
				(b.field_length == 0 || b.field_length > MAX_UNSIGNED_LEN))
			return 1'b1;
		if (b.kind == KIND_SIGNED &&
				(b.field_length == 0 || b.field_length > MAX_SIGNED_LEN))
			return 1'b1;
		if (b.kind != KIND_UNSIGNED && b.kind != KIND_SIGNED)
			return 1'b1;
		first = b.bit_offset >> 3;
		last = (b.bit_offset + b.field_length - 1) >> 3;
		if (last > BUF_BYTES - 1)
			last = BUF_BYTES - 1;
		for (int unsigned i = first; i <= last; i++)
			if (i < msg_len && !msg_written[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic in_item_t make_beat(logic [1:0] k, logic [5:0] idx, logic [7:0] val,
			logic [8:0] off, logic [6:0] len);
		in_item_t b;
		b.kind = k;
		b.byte_index = idx;
		b.byte_value = val;
		b.bit_offset = off;
		b.field_length = len;
		return b;
	endfunction

	// Random field read, mostly inside the given span, with some bad lengths.
	function automatic in_item_t pick_extract(int unsigned span_bits);
		in_item_t b;
		int unsigned r;
		for (int tries = 0; tries < 16; tries++) begin
			b = make_beat($urandom_range(0, 1) ? KIND_SIGNED : KIND_UNSIGNED,
				6'($urandom), 8'($urandom), 9'($urandom), 7'd0);
			if ($urandom_range(0, 3) != 0)
				b.bit_offset = 9'($urandom_range(0, span_bits - 1));
			r = $urandom_range(0, 19);
			if (r == 0)
				b.field_length = 7'd0;
			else if (r <= 2)
				b.field_length = (b.kind == KIND_SIGNED) ? 7'($urandom_range(33, 127))
					: 7'($urandom_range(65, 127));
			else
				b.field_length = (b.kind == KIND_SIGNED) ? 7'($urandom_range(1, 32))
					: 7'($urandom_range(1, 64));
			if (reads_ok(b))
				return b;
		end
		b.field_length = 7'd0;
		return b;
	endfunction

	// Offers one beat from a falling edge and returns at the falling edge
	// after it was taken. Gaps fall between bursts of random length.
	task automatic send_beat(input in_item_t b, input bit typed, input out_item_t res);
		int gap;
		int target;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		push <= 1'b1;
		item <= b;
		drv_typed <= typed;
		drv_res <= res;
		target = beats_taken + 1;
		do @(negedge clk); while (beats_taken != target);
		burst_left--;
	endtask

	// Stops offering and waits until every pending field has come out.
	task automatic drain_fields();
		push <= 1'b0;
		@(negedge clk);
		while (pending_fields.size() != 0)
			@(negedge clk);
	endtask

	// Adds one row to the directed table.
	task automatic add_row(input in_item_t b, input bit typed, input logic [63:0] value,
			input logic err);
		stim_row_t row;
		row.beat = b;
		row.typed = typed;
		row.res.field_value = value;
		row.res.length_error = err;
		dir_rows.push_back(row);
	endtask

	// Result side: stalls on a pattern of its own, with one long hold-off.
	initial begin
		int mode;
		int stretch;
		pop = 1'b0;
		mode = 0;
		stretch = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			if (stretch == 0) begin
				mode = $urandom_range(0, 2);
				stretch = $urandom_range(20, 150);
			end
			stretch--;
			case (mode)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				default: pop <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Checks each result beat against the oldest pending field, then
	// predicts the field of each accepted input beat.
	always @(posedge clk) begin
		bit has_res;
		out_item_t res;
		out_item_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_fields.size() == 0) begin
					$display("%0t: result beat with nothing pending, got value %h error %b",
						$time, result.field_value, result.length_error);
					fail_count++;
				end else begin
					want = pending_fields.pop_front();
					if (result.field_value !== want.field_value) begin
						$display("%0t: field_value mismatch, expected %h got %h",
							$time, want.field_value, result.field_value);
						fail_count++;
					end
					if (result.length_error !== want.length_error) begin
						$display("%0t: length_error mismatch, expected %b got %b",
							$time, want.length_error, result.length_error);
						fail_count++;
					end
				end
			end
			if (push && !full) begin
				apply_beat(item, has_res, res);
				if (has_res)
					pending_fields.push_back(drv_typed ? drv_res : res);
				beats_taken++;
			end
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// Watchdog on cycles with no beat moving on either side.
	initial begin
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Stimulus: directed table first, then random message traffic.
	initial begin
		logic [7:0] head_bytes [9];
		in_item_t b;
		int unsigned n;
		int unsigned reads;
		int random_done;
		bit drained;
		bit held;

		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		drv_typed = 1'b0;
		drv_res = '0;
		hold_req = 1'b0;
		fail_count = 0;
		beats_taken = 0;
		idle_cycles = 0;
		burst_left = 0;
		msg_len = '0;
		for (int i = 0; i < BUF_BYTES; i++) begin
			msg_bytes[i] = '0;
			msg_written[i] = 1'b0;
		end
		head_bytes = '{8'h80, 8'hA5, 8'h3C, 8'hFF, 8'h00, 8'h5A, 8'hC3, 8'h12, 8'hEF};

		// Read from an empty buffer, then the length limits of both modes.
		add_row(make_beat(KIND_UNSIGNED, 0, 0, 0, 8), 1, 64'd0, 1'b0);
		add_row(make_beat(KIND_UNSIGNED, 0, 0, 0, 0), 1, 64'd0, 1'b1);
		add_row(make_beat(KIND_UNSIGNED, 0, 0, 9, 65), 1, 64'd0, 1'b1);
		add_row(make_beat(KIND_SIGNED, 0, 0, 0, 33), 1, 64'd0, 1'b1);
		add_row(make_beat(KIND_SIGNED, 0, 0, 0, 127), 1, 64'd0, 1'b1);
		add_row(make_beat(KIND_UNUSED, 63, 8'hFF, 511, 127), 0, 64'd0, 1'b0);
		// A nine-byte message head, then full-width reads across it.
		for (int i = 0; i < 9; i++)
			add_row(make_beat(KIND_LOAD, 6'(i), head_bytes[i], 0, 0), 0, 64'd0, 1'b0);
		add_row(make_beat(KIND_UNSIGNED, 0, 0, 0, 64), 0, 64'd0, 1'b0);
		add_row(make_beat(KIND_UNSIGNED, 0, 0, 3, 64), 0, 64'd0, 1'b0);
		add_row(make_beat(KIND_SIGNED, 0, 0, 8, 32), 0, 64'd0, 1'b0);
		// Signed field of length one is always zero; unsigned bit reads one.
		add_row(make_beat(KIND_SIGNED, 0, 0, 0, 1), 1, 64'd0, 1'b0);
		add_row(make_beat(KIND_UNSIGNED, 0, 0, 0, 1), 1, 64'd1, 1'b0);
		// Last byte of the buffer and reads running off its end.
		add_row(make_beat(KIND_LOAD, 63, 8'hFF, 0, 0), 0, 64'd0, 1'b0);
		add_row(make_beat(KIND_UNSIGNED, 0, 0, 504, 8), 1, 64'hFF, 1'b0);
		add_row(make_beat(KIND_UNSIGNED, 0, 0, 511, 64), 1, 64'h8000_0000_0000_0000, 1'b0);
		// Negative zero comes back as zero.
		add_row(make_beat(KIND_SIGNED, 0, 0, 511, 32), 1, 64'd0, 1'b0);
		// A load at index zero shrinks the message back to one byte.
		add_row(make_beat(KIND_LOAD, 0, 8'h7F, 0, 0), 0, 64'd0, 1'b0);
		add_row(make_beat(KIND_UNSIGNED, 0, 0, 0, 64), 0, 64'd0, 1'b0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].res);
		drain_fields();

		// Random part: mostly whole messages followed by reads, plus noise.
		random_done = 0;
		drained = 1'b0;
		held = 1'b0;
		while (random_done < RANDOM_BEATS) begin
			if (!drained && random_done >= 300) begin
				drain_fields();
				drained = 1'b1;
			end
			if (!held && random_done >= 500) begin
				hold_req = 1'b1;
				burst_left = 80;
				held = 1'b1;
			end
			if ($urandom_range(0, 9) < 6) begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
				for (int unsigned i = 0; i < n; i++)
					send_beat(make_beat(KIND_LOAD, 6'(i), 8'($urandom), 9'($urandom),
						7'($urandom)), 0, '0);
				reads = $urandom_range(1, 10);
				for (int unsigned i = 0; i < reads; i++)
					send_beat(pick_extract(n * 8), 0, '0);
				random_done += n + reads;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						b = make_beat(KIND_LOAD, 6'($urandom), 8'($urandom), 9'($urandom),
							7'($urandom));
						random_done++;
					end
					4: b = make_beat(KIND_UNUSED, 6'($urandom), 8'($urandom), 9'($urandom),
						7'($urandom));
					default: begin
						b = pick_extract(512);
						random_done++;
					end
				endcase
				send_beat(b, 0, '0);
			end
		end

		// Let everything come out, then allow a few extract times more.
		drain_fields();
		repeat (SETTLE) @(negedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: message_bit_field_extractor_top.f
+incdir+design
design/mbfe_pkg.sv
design/mbfe_cmd_queue.sv
design/mbfe_front.sv
design/mbfe_back.sv
design/message_bit_field_extractor_top.sv
design/mbfe_checker.sv
test/testbench.sv
